// ===== design/psp_pkg.sv =====
`timescale 1ns / 1ps

package psp_pkg;

   // Parser phases. The width start phase always hands a character on to a later
   // phase, so its code is never held in the state register.
   localparam logic [3:0] PH_START  = 4'd0;
   localparam logic [3:0] PH_FLAGS  = 4'd1;
   localparam logic [3:0] PH_WSTART = 4'd2;
   localparam logic [3:0] PH_WDIG   = 4'd3;
   localparam logic [3:0] PH_DOTQ   = 4'd4;
   localparam logic [3:0] PH_PSTART = 4'd5;
   localparam logic [3:0] PH_PDIG   = 4'd6;
   localparam logic [3:0] PH_LEN    = 4'd7;
   localparam logic [3:0] PH_DONE   = 4'd8;
   localparam logic [3:0] PH_BAD    = 4'd9;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_DOT     = 8'h2E;

   localparam logic [1:0] FILL_NONE  = 2'd0;
   localparam logic [1:0] FILL_SPACE = 2'd1;
   localparam logic [1:0] FILL_ZERO  = 2'd2;

   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;

   typedef struct packed {
      logic              plus_seen;
      logic              minus_seen;
      logic [1:0]        fill_sel;
      logic              hash_seen;
      logic              have_width;
      logic signed [31:0] width_acc;
      logic signed [31:0] prec_acc;
      logic [7:0]        conv_seen;
      logic              bad_seen;
   } spec_fields_type;

   typedef struct packed {
      logic [3:0]      phase;
      spec_fields_type fields;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase:  PH_START,
      fields: '{
         plus_seen:  1'b0,
         minus_seen: 1'b0,
         fill_sel:   FILL_NONE,
         hash_seen:  1'b0,
         have_width: 1'b0,
         width_acc:  32'sd0,
         prec_acc:   -32'sd1,
         conv_seen:  8'h00,
         bad_seen:   1'b0
      }
   };

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_length(input logic [7:0] c);
      return c inside {8'h61, 8'h68, 8'h6C, 8'h4C, 8'h6D};
   endfunction

   function automatic logic is_conv(input logic [7:0] c);
      return c inside {8'h63, 8'h73, 8'h64, 8'h69, 8'h6F, 8'h78, 8'h58, 8'h75,
                       8'h66, 8'h46, 8'h65, 8'h45, 8'h61, 8'h41, 8'h67, 8'h47,
                       8'h6E, 8'h70};
   endfunction

   // Decimal accumulate, acc * 10 + digit, saturating at the largest int.
   function automatic logic [31:0] accumulate(input logic [31:0] acc, input logic [7:0] c);
      logic [35:0] v;
      v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {32'b0, c[3:0]};
      return (v > {4'b0, SAT_MAX}) ? SAT_MAX : v[31:0];
   endfunction

endpackage

// ===== design/psp_step.sv =====
`timescale 1ns / 1ps

// Next parser state for one non-NUL character. The phases are tried in
// grammar order; a character that a phase does not take falls to the next one.
module psp_step (
   input  psp_pkg::parse_state_type cur,
   input  logic [7:0]               ch,
   input  logic signed [31:0]       star,
   output psp_pkg::parse_state_type nxt
);

   logic [3:0] ph;
   logic       done;

   always_comb begin
      nxt  = cur;
      ph   = cur.phase;
      done = 1'b0;

      if (ph == psp_pkg::PH_START) begin
         ph = psp_pkg::PH_FLAGS;
         if (ch == psp_pkg::CH_PERCENT) begin
            done = 1'b1;
         end
      end

      if (!done && ph == psp_pkg::PH_FLAGS) begin
         done = 1'b1;
         case (ch)
            psp_pkg::CH_PLUS:  nxt.fields.plus_seen  = 1'b1;
            psp_pkg::CH_MINUS: nxt.fields.minus_seen = 1'b1;
            psp_pkg::CH_SPACE: nxt.fields.fill_sel   = psp_pkg::FILL_SPACE;
            psp_pkg::CH_ZERO:  nxt.fields.fill_sel   = psp_pkg::FILL_ZERO;
            psp_pkg::CH_HASH:  nxt.fields.hash_seen  = 1'b1;
            default: begin
               done = 1'b0;
               ph   = psp_pkg::PH_WSTART;
            end
         endcase
      end

      if (!done && ph == psp_pkg::PH_WSTART) begin
         if (psp_pkg::is_digit(ch)) begin
            nxt.fields.have_width = 1'b1;
            nxt.fields.width_acc  = {28'b0, ch[3:0]};
            ph   = psp_pkg::PH_WDIG;
            done = 1'b1;
         end else if (ch == psp_pkg::CH_STAR) begin
            nxt.fields.have_width = 1'b1;
            nxt.fields.width_acc  = star;
            ph   = psp_pkg::PH_DOTQ;
            done = 1'b1;
         end else begin
            ph = psp_pkg::PH_DOTQ;
         end
      end

      if (!done && ph == psp_pkg::PH_WDIG) begin
         if (psp_pkg::is_digit(ch)) begin
            nxt.fields.width_acc = psp_pkg::accumulate(cur.fields.width_acc, ch);
            done = 1'b1;
         end else begin
            ph = psp_pkg::PH_DOTQ;
         end
      end

      if (!done && ph == psp_pkg::PH_DOTQ) begin
         if (ch == psp_pkg::CH_DOT) begin
            ph   = psp_pkg::PH_PSTART;
            done = 1'b1;
         end else begin
            ph = psp_pkg::PH_LEN;
         end
      end

      if (!done && ph == psp_pkg::PH_PSTART) begin
         if (psp_pkg::is_digit(ch)) begin
            nxt.fields.prec_acc = {28'b0, ch[3:0]};
            ph   = psp_pkg::PH_PDIG;
            done = 1'b1;
         end else if (ch == psp_pkg::CH_STAR) begin
            nxt.fields.prec_acc = star;
            ph   = psp_pkg::PH_LEN;
            done = 1'b1;
         end else begin
            ph = psp_pkg::PH_LEN;
         end
      end

      if (!done && ph == psp_pkg::PH_PDIG) begin
         if (psp_pkg::is_digit(ch)) begin
            nxt.fields.prec_acc = psp_pkg::accumulate(cur.fields.prec_acc, ch);
            done = 1'b1;
         end else begin
            ph = psp_pkg::PH_LEN;
         end
      end

      if (!done) begin
         if (ph == psp_pkg::PH_LEN && psp_pkg::is_length(ch)) begin
            // Length modifiers are accepted and dropped.
         end else if (ph == psp_pkg::PH_LEN && psp_pkg::is_conv(ch)) begin
            nxt.fields.conv_seen = ch;
            ph = psp_pkg::PH_DONE;
         end else begin
            nxt.fields.bad_seen = 1'b1;
            ph = psp_pkg::PH_BAD;
         end
      end

      nxt.phase = ph;
   end

endmodule

// ===== design/printf_spec_parser_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_ch, req_star_value
// rsp       out        rsp_valid / rsp_stall  rsp_sign_plus ... rsp_spec_valid
//
// One character per cycle while req_stall is low. A character is registered, then the
// parser state is updated from it; a NUL beat loads the result register once no
// result is stalled, and returns the parser to its start state.
// Synchronous active-high reset clears the parser state and both valid flags.
// Only a NUL waiting behind an untaken result holds the input stage, so
// req_stall rises only while a result is stalled and another NUL is queued.
module printf_spec_parser_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_ch,
   input  logic signed [31:0] req_star_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_sign_plus,
   output logic               rsp_left_align,
   output logic [1:0]         rsp_fill_mode,
   output logic               rsp_alt_form,
   output logic               rsp_width_given,
   output logic signed [31:0] rsp_field_width,
   output logic signed [31:0] rsp_prec_value,
   output logic [7:0]         rsp_conv_char,
   output logic               rsp_spec_valid
);

   logic                      in_valid_ff;
   logic [7:0]                in_ch_ff;
   logic signed [31:0]        in_star_ff;
   psp_pkg::parse_state_type  state_ff;
   psp_pkg::parse_state_type  state_in;
   psp_pkg::parse_state_type  step_nxt;
   psp_pkg::spec_fields_type  rsp_ff;
   logic                      rsp_valid_ff;
   logic                      in_nul;
   logic                      in_go;
   logic                      req_take;

   assign in_nul    = (in_ch_ff == psp_pkg::CH_NUL);
   assign in_go     = in_valid_ff && (!in_nul || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !in_go;
   assign req_take  = req_valid && !req_stall;

   psp_step u_step (
      .cur  (state_ff),
      .ch   (in_ch_ff),
      .star (in_star_ff),
      .nxt  (step_nxt)
   );

   always_comb begin
      state_in = state_ff;
      if (in_go) begin
         state_in = in_nul ? psp_pkg::STATE_RESET : step_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= psp_pkg::STATE_RESET;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (in_go) begin
            in_valid_ff <= 1'b0;
         end
         if (in_go && in_nul) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ch_ff   <= req_ch;
         in_star_ff <= req_star_value;
      end
      if (in_go && in_nul) begin
         rsp_ff <= state_ff.fields;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sign_plus   = rsp_ff.plus_seen;
   assign rsp_left_align  = rsp_ff.minus_seen;
   assign rsp_fill_mode   = rsp_ff.fill_sel;
   assign rsp_alt_form    = rsp_ff.hash_seen;
   assign rsp_width_given = rsp_ff.have_width;
   assign rsp_field_width = rsp_ff.width_acc;
   assign rsp_prec_value  = rsp_ff.prec_acc;
   assign rsp_conv_char   = rsp_ff.conv_seen;
   assign rsp_spec_valid  = !rsp_ff.bad_seen;

endmodule
